// ===== hw/rtl/rrbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbm_pkg
// Shared types and constants for the ROM/RAM bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbm_pkg;

  localparam int unsigned MAX_ROM_BANKS_DEF = 128;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned MADDR_W    = 21;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ROM_BANK_W = 7;
  localparam int unsigned LOW_BANK_W = 5;
  localparam int unsigned HIGH_BANK_W = 2;
  localparam int unsigned ROM_OFS_W  = 14;
  localparam int unsigned RAM_OFS_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LOG2  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] ROM_LOG2_RESET  = 3'd1;
  localparam logic [CFG_W-1:0] RAM_COUNT_RESET = 3'd0;
  localparam logic [CFG_W-1:0] RAM_COUNT_MAX   = 3'd4;

  // bus regions, address bits 15:13
  localparam logic [2:0] RGN_RAM_EN  = 3'd0;
  localparam logic [2:0] RGN_LOW     = 3'd1;
  localparam logic [2:0] RGN_HIGH    = 3'd2;
  localparam logic [2:0] RGN_MODE    = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM = 3'd5;

  localparam logic [3:0]      RAM_EN_KEY    = 4'hA;
  localparam logic [DATA_W-1:0] DATA_DISABLED = 8'hFF;
  localparam logic [DATA_W-1:0] DATA_UNMAPPED = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 3'd0,
    KIND_ROM_READ  = 3'd1,
    KIND_RAM_READ  = 3'd2,
    KIND_RAM_WRITE = 3'd3,
    KIND_FIXED     = 3'd4
  } access_kind_e;

  typedef struct packed {
    logic                   ram_enabled;
    logic [LOW_BANK_W-1:0]  low_bank;
    logic [HIGH_BANK_W-1:0] high_bank;
    logic                   advanced_mode;
  } bank_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] rom_log2;
    logic [CFG_W-1:0] ram_count;
  } map_cfg_t;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_req_t;

  typedef struct packed {
    access_kind_e       kind;
    logic [MADDR_W-1:0] maddr;
    logic [DATA_W-1:0]  wdata;
    logic [DATA_W-1:0]  fixed;
  } map_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// rrbm_bank_regs
// Mapper bank registers and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbm_bank_regs
  import rrbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 upd_en_i,
  input  bank_state_t          state_d_i,
  output bank_state_t          state_o,
  output map_cfg_t             cfg_o
);

  bank_state_t state_q;
  map_cfg_t    cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.ram_enabled   <= 1'b0;
      state_q.low_bank      <= LOW_BANK_W'(1);
      state_q.high_bank     <= '0;
      state_q.advanced_mode <= 1'b0;
    end else if (upd_en_i) begin
      state_q <= state_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_log2  <= ROM_LOG2_RESET;
      cfg_q.ram_count <= RAM_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROM_LOG2:  cfg_q.rom_log2  <= cfg_data_i;
        CFG_RAM_COUNT: cfg_q.ram_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign state_o = state_q;
  assign cfg_o   = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rrbm_map.sv =====
// ----------------------------------------------------------------------------
// rrbm_map
// Address decode, bank mapping and next bank register values for one access.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbm_map
  import rrbm_pkg::*;
#(
  parameter int unsigned MaxRomBanks = MAX_ROM_BANKS_DEF
) (
  input  bus_req_t    req_i,
  input  bank_state_t state_i,
  input  map_cfg_t    cfg_i,
  output bank_state_t state_d_o,
  output map_rsp_t    rsp_o
);

  localparam logic [ROM_BANK_W-1:0] MaskLimit = ROM_BANK_W'(MaxRomBanks - 1);

  logic [CFG_W-1:0]       rom_lg;
  logic [ROM_BANK_W:0]    lg_ones;
  logic [ROM_BANK_W-1:0]  rom_mask;
  logic [CFG_W-1:0]       ram_cnt;
  logic [HIGH_BANK_W-1:0] ram_mask;
  logic [HIGH_BANK_W-1:0] ram_bank;
  logic                   ram_present;
  logic                   ram_on;
  logic [2:0]             region;
  logic [LOW_BANK_W-1:0]  low_val;
  logic [ROM_BANK_W-1:0]  bank_lo;
  logic [ROM_BANK_W-1:0]  bank_hi;
  logic [MADDR_W-1:0]     rom_lo_addr;
  logic [MADDR_W-1:0]     rom_hi_addr;
  logic [MADDR_W-1:0]     ram_addr;

  always_comb begin
    rom_lg   = (cfg_i.rom_log2 == '0) ? CFG_W'(1) : cfg_i.rom_log2;
    lg_ones  = ((ROM_BANK_W+1)'(1) << rom_lg) - (ROM_BANK_W+1)'(1);
    rom_mask = lg_ones[ROM_BANK_W-1:0] & MaskLimit;

    ram_cnt     = (cfg_i.ram_count > RAM_COUNT_MAX) ? RAM_COUNT_MAX : cfg_i.ram_count;
    ram_present = (ram_cnt != '0);
    ram_mask    = HIGH_BANK_W'(ram_cnt - CFG_W'(1));
    ram_bank    = (state_i.advanced_mode && ram_present) ?
                  (state_i.high_bank & ram_mask) : '0;
    ram_on      = state_i.ram_enabled && ram_present;

    region  = req_i.addr[ADDR_W-1 -: 3];
    low_val = (req_i.data[LOW_BANK_W-1:0] == '0) ? LOW_BANK_W'(1)
                                                 : req_i.data[LOW_BANK_W-1:0];

    bank_lo = state_i.advanced_mode ?
              ({state_i.high_bank, {LOW_BANK_W{1'b0}}} & rom_mask) : '0;
    bank_hi = {state_i.high_bank, state_i.low_bank} & rom_mask;

    rom_lo_addr = {bank_lo, req_i.addr[ROM_OFS_W-1:0]};
    rom_hi_addr = {bank_hi, req_i.addr[ROM_OFS_W-1:0]};
    ram_addr    = MADDR_W'({ram_bank, req_i.addr[RAM_OFS_W-1:0]});
  end

  always_comb begin
    state_d_o   = state_i;
    rsp_o.kind  = KIND_NONE;
    rsp_o.maddr = '0;
    rsp_o.wdata = '0;
    rsp_o.fixed = '0;
    if (req_i.is_write) begin
      case (region)
        RGN_RAM_EN: begin
          if (ram_present) begin
            state_d_o.ram_enabled = (req_i.data[3:0] == RAM_EN_KEY);
          end
        end
        RGN_LOW: begin
          state_d_o.low_bank = low_val & rom_mask[LOW_BANK_W-1:0];
        end
        RGN_HIGH: begin
          state_d_o.high_bank = req_i.data[HIGH_BANK_W-1:0];
        end
        RGN_MODE: begin
          if (ram_cnt >= RAM_COUNT_MAX) begin
            state_d_o.advanced_mode = req_i.data[0];
          end
        end
        RGN_EXT_RAM: begin
          if (ram_on) begin
            rsp_o.kind  = KIND_RAM_WRITE;
            rsp_o.maddr = ram_addr;
            rsp_o.wdata = req_i.data;
          end
        end
        default: ;
      endcase
    end else begin
      case (region)
        RGN_RAM_EN, RGN_LOW: begin
          rsp_o.kind  = KIND_ROM_READ;
          rsp_o.maddr = rom_lo_addr;
        end
        RGN_HIGH, RGN_MODE: begin
          rsp_o.kind  = KIND_ROM_READ;
          rsp_o.maddr = rom_hi_addr;
        end
        RGN_EXT_RAM: begin
          if (ram_on) begin
            rsp_o.kind  = KIND_RAM_READ;
            rsp_o.maddr = ram_addr;
          end else begin
            rsp_o.kind  = KIND_FIXED;
            rsp_o.fixed = DATA_DISABLED;
          end
        end
        default: begin
          rsp_o.kind  = KIND_FIXED;
          rsp_o.fixed = DATA_UNMAPPED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rom_ram_bank_mapper_core.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_core
// Cartridge bank mapper: one bus access in, one mapped memory request out.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o   req_type, bus_address, write_data
//   out      source     out_valid_o/out_ready_i access_kind, mapped_address,
//                                                memory_write_data, fixed_data
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; the
// input register captures an accepted request, and the result register takes
// its mapped result as the request leaves the input register
// bank registers update as the request leaves the input register
// a stalled output holds the result register and then the input register
// cfg is always ready; reset gives log2 rom banks 1, no ram, bank 1
// ----------------------------------------------------------------------------
`default_nettype none

module rom_ram_bank_mapper_core
  import rrbm_pkg::*;
#(
  parameter int unsigned MaxRomBanks = MAX_ROM_BANKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [ADDR_W-1:0]    bus_address_i,
  input  logic [DATA_W-1:0]    write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [KIND_W-1:0]    access_kind_o,
  output logic [MADDR_W-1:0]   mapped_address_o,
  output logic [DATA_W-1:0]    memory_write_data_o,
  output logic [DATA_W-1:0]    fixed_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic        req_valid_q;
  bus_req_t    req_q;
  logic        rsp_valid_q;
  map_rsp_t    rsp_q;
  logic        rsp_advance;
  logic        req_advance;
  logic        in_accept;
  bank_state_t state;
  bank_state_t state_d;
  map_cfg_t    cfg;
  map_rsp_t    rsp_d;

  assign rsp_advance = !rsp_valid_q || out_ready_i;
  assign req_advance = req_valid_q && rsp_advance;
  assign in_ready_o  = !req_valid_q || rsp_advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.is_write <= req_type_i;
      req_q.addr     <= bus_address_i;
      req_q.data     <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_advance) begin
      rsp_q <= rsp_d;
    end
  end

  rrbm_bank_regs u_bank_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_en_i    (req_advance),
    .state_d_i   (state_d),
    .state_o     (state),
    .cfg_o       (cfg)
  );

  rrbm_map #(
    .MaxRomBanks (MaxRomBanks)
  ) u_map (
    .req_i     (req_q),
    .state_i   (state),
    .cfg_i     (cfg),
    .state_d_o (state_d),
    .rsp_o     (rsp_d)
  );

  assign out_valid_o         = rsp_valid_q;
  assign access_kind_o       = rsp_q.kind;
  assign mapped_address_o    = rsp_q.maddr;
  assign memory_write_data_o = rsp_q.wdata;
  assign fixed_data_o        = rsp_q.fixed;

endmodule

`default_nettype wire

// ===== verif/mapper_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mapper_checker
// Watches the bus, result and register channels of the bank mapper, keeps
// its own copy of the bank registers and configuration, predicts the memory
// request for every accepted bus access and compares each accepted result
// with the oldest prediction. Hands the number of failures and the number of
// predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module mapper_checker
  import rrbm_pkg::*;
#(
  parameter int unsigned MaxRomBanks = MAX_ROM_BANKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 req_type_i,
  input  logic [ADDR_W-1:0]    bus_address_i,
  input  logic [DATA_W-1:0]    write_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [KIND_W-1:0]    access_kind_i,
  input  logic [MADDR_W-1:0]   mapped_address_i,
  input  logic [DATA_W-1:0]    memory_write_data_i,
  input  logic [DATA_W-1:0]    fixed_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  map_cfg_t    cfg_q;
  bank_state_t bank_q;
  map_rsp_t    mem_req_q[$];
  int          fails;

  function automatic logic [ROM_BANK_W-1:0] rom_bank_mask(input logic [CFG_W-1:0] lg2);
    logic [CFG_W-1:0]      lg;
    logic [ROM_BANK_W:0]   full;
    logic [ROM_BANK_W-1:0] lim;
    lg   = (lg2 == '0) ? 3'd1 : lg2;
    full = (8'd1 << lg) - 8'd1;
    lim  = ROM_BANK_W'(MaxRomBanks - 1);
    return full[ROM_BANK_W-1:0] & lim;
  endfunction

  function automatic logic [CFG_W-1:0] ram_banks(input logic [CFG_W-1:0] count);
    return (count > RAM_COUNT_MAX) ? RAM_COUNT_MAX : count;
  endfunction

  // maps one bus access and applies its register write
  function automatic map_rsp_t map_access(input logic wr, input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] d);
    map_rsp_t               r;
    logic [2:0]             rgn;
    logic [CFG_W-1:0]       nram;
    logic [CFG_W-1:0]       rsel;
    logic [ROM_BANK_W-1:0]  mask;
    logic [ROM_BANK_W-1:0]  bank;
    logic [HIGH_BANK_W-1:0] rbank;
    logic [LOW_BANK_W-1:0]  lb;
    logic                   ram_on;
    r      = '0;
    r.kind = KIND_NONE;
    rgn    = a[15:13];
    nram   = ram_banks(cfg_q.ram_count);
    mask   = rom_bank_mask(cfg_q.rom_log2);
    ram_on = bank_q.ram_enabled && (nram != 0);
    rsel   = nram - 3'd1;
    rbank  = (bank_q.advanced_mode && nram != 0) ?
             (bank_q.high_bank & rsel[HIGH_BANK_W-1:0]) : '0;
    if (wr) begin
      case (rgn)
        RGN_RAM_EN: if (nram != 0) bank_q.ram_enabled = (d[3:0] == RAM_EN_KEY);
        RGN_LOW: begin
          lb = d[LOW_BANK_W-1:0];
          if (lb == '0) lb = 5'd1;
          bank_q.low_bank = lb & mask[LOW_BANK_W-1:0];
        end
        RGN_HIGH: bank_q.high_bank = d[HIGH_BANK_W-1:0];
        RGN_MODE: if (nram >= RAM_COUNT_MAX) bank_q.advanced_mode = d[0];
        RGN_EXT_RAM: begin
          if (ram_on) begin
            r.kind  = KIND_RAM_WRITE;
            r.maddr = MADDR_W'({rbank, a[RAM_OFS_W-1:0]});
            r.wdata = d;
          end
        end
        default: ;
      endcase
    end else begin
      case (rgn)
        RGN_RAM_EN, RGN_LOW: begin
          bank    = bank_q.advanced_mode ? ({bank_q.high_bank, 5'b0} & mask) : '0;
          r.kind  = KIND_ROM_READ;
          r.maddr = {bank, a[ROM_OFS_W-1:0]};
        end
        RGN_HIGH, RGN_MODE: begin
          bank    = {bank_q.high_bank, bank_q.low_bank} & mask;
          r.kind  = KIND_ROM_READ;
          r.maddr = {bank, a[ROM_OFS_W-1:0]};
        end
        RGN_EXT_RAM: begin
          if (ram_on) begin
            r.kind  = KIND_RAM_READ;
            r.maddr = MADDR_W'({rbank, a[RAM_OFS_W-1:0]});
          end else begin
            r.kind  = KIND_FIXED;
            r.fixed = DATA_DISABLED;
          end
        end
        default: begin
          r.kind  = KIND_FIXED;
          r.fixed = DATA_UNMAPPED;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_rsp_t want;
    if (!rst_ni) begin
      cfg_q.rom_log2       = ROM_LOG2_RESET;
      cfg_q.ram_count      = RAM_COUNT_RESET;
      bank_q.ram_enabled   = 1'b0;
      bank_q.low_bank      = 5'd1;
      bank_q.high_bank     = '0;
      bank_q.advanced_mode = 1'b0;
      mem_req_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result side first: a result never belongs to an access of the same edge
      if (out_valid_i && out_ready_i) begin
        if (mem_req_q.size() == 0) begin
          $error("result transaction with no access waiting: access_kind %0d", access_kind_i);
          fails++;
        end else begin
          want = mem_req_q.pop_front();
          if (access_kind_i !== want.kind) begin
            $error("access_kind: expected %0d, actual %0d", want.kind, access_kind_i);
            fails++;
          end
          if (mapped_address_i !== want.maddr) begin
            $error("mapped_address: expected 0x%06h, actual 0x%06h", want.maddr,
                   mapped_address_i);
            fails++;
          end
          if (memory_write_data_i !== want.wdata) begin
            $error("memory_write_data: expected 0x%02h, actual 0x%02h", want.wdata,
                   memory_write_data_i);
            fails++;
          end
          if (fixed_data_i !== want.fixed) begin
            $error("fixed_data: expected 0x%02h, actual 0x%02h", want.fixed, fixed_data_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROM_LOG2:  cfg_q.rom_log2  = cfg_data_i;
          CFG_RAM_COUNT: cfg_q.ram_count = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        mem_req_q.insert(mem_req_q.size(),
                         map_access(req_type_i, bus_address_i, write_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= mem_req_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Bus access stimulus for the ROM/RAM bank mapper: a directed pass over the
// address regions and register rules, then random accesses under a series
// of ROM and RAM size settings, with random gaps on the bus side and random
// stalls on the result side. Checking is done by mapper_checker.
// ----------------------------------------------------------------------------
module testbench;
  import rrbm_pkg::*;

  localparam logic        REQ_READ   = 1'b0;
  localparam logic        REQ_WRITE  = 1'b1;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned Phases     = 10;
  localparam int unsigned PhaseItems = 170;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i    = 1'b0;
  logic [ADDR_W-1:0]    bus_address_i = '0;
  logic [DATA_W-1:0]    write_data_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [KIND_W-1:0]    access_kind_o;
  logic [MADDR_W-1:0]   mapped_address_o;
  logic [DATA_W-1:0]    memory_write_data_o;
  logic [DATA_W-1:0]    fixed_data_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  int          fail_count;
  int          pending;
  int unsigned cycles  = 0;
  bit          no_gaps = 1'b0;

  always #10 clk_i = ~clk_i;

  rom_ram_bank_mapper_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .bus_address_i       (bus_address_i),
    .write_data_i        (write_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .access_kind_o       (access_kind_o),
    .mapped_address_o    (mapped_address_o),
    .memory_write_data_o (memory_write_data_o),
    .fixed_data_o        (fixed_data_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  mapper_checker map_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .req_type_i          (req_type_i),
    .bus_address_i       (bus_address_i),
    .write_data_i        (write_data_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .access_kind_i       (access_kind_o),
    .mapped_address_i    (mapped_address_o),
    .memory_write_data_i (memory_write_data_o),
    .fixed_data_i        (fixed_data_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= wr;
    bus_address_i <= a;
    write_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // mostly register writes, ROM reads and RAM accesses, some pure noise
  task automatic send_random_access();
    int unsigned       pick;
    logic              wr;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    wr   = 1'($urandom);
    a    = ADDR_W'($urandom);
    d    = DATA_W'($urandom);
    if (pick < 35) begin
      wr        = REQ_WRITE;
      a[15:13]  = 3'($urandom_range(0, 3));
      if (a[15:13] == RGN_RAM_EN && $urandom_range(0, 1) == 1) d[3:0] = RAM_EN_KEY;
    end else if (pick < 60) begin
      wr    = REQ_READ;
      a[15] = 1'b0;
    end else if (pick < 90) begin
      a[15:13] = RGN_EXT_RAM;
    end
    send_access(wr, a, d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] rom_sel;
    logic [CFG_W-1:0] ram_sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: two rom banks, no ram
    send_access(REQ_READ,  16'h0000, 8'h00);
    send_access(REQ_READ,  16'h3FFF, 8'hFF);
    send_access(REQ_READ,  16'h4000, 8'h00);
    send_access(REQ_READ,  16'h7FFF, 8'hFF);
    send_access(REQ_READ,  16'h8000, 8'h00);
    send_access(REQ_READ,  16'hFFFF, 8'hFF);
    send_access(REQ_WRITE, 16'h0000, 8'h0A);
    send_access(REQ_READ,  16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'hBFFF, 8'h55);
    send_access(REQ_WRITE, 16'hC000, 8'hFF);
    send_access(REQ_WRITE, 16'h2000, 8'h00);
    send_access(REQ_WRITE, 16'h3FFF, 8'hFF);
    send_access(REQ_WRITE, 16'h4000, 8'hFF);
    send_access(REQ_WRITE, 16'h6000, 8'h01);
    send_access(REQ_READ,  16'h4000, 8'h00);

    // largest rom, four ram banks
    write_reg(CFG_ROM_LOG2, 3'd7);
    write_reg(CFG_RAM_COUNT, 3'd4);
    send_access(REQ_WRITE, 16'h1FFF, 8'hFA);
    send_access(REQ_WRITE, 16'h7FFF, 8'h01);
    send_access(REQ_WRITE, 16'h2000, 8'h1F);
    send_access(REQ_READ,  16'h0000, 8'h00);
    send_access(REQ_READ,  16'h5FFF, 8'h00);
    send_access(REQ_READ,  16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'hA000, 8'h00);
    send_access(REQ_READ,  16'hBFFF, 8'h00);
    send_access(REQ_WRITE, 16'h0000, 8'h00);
    send_access(REQ_READ,  16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'h6000, 8'h00);

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: begin rom_sel = 3'd0; ram_sel = 3'd0; end
        1: begin rom_sel = 3'd7; ram_sel = 3'd7; end
        2: begin rom_sel = 3'd1; ram_sel = 3'd4; end
        3: begin rom_sel = 3'd7; ram_sel = 3'd1; end
        4: begin rom_sel = 3'd3; ram_sel = 3'd2; end
        5: begin rom_sel = 3'd2; ram_sel = 3'd3; end
        default: begin
          rom_sel = CFG_W'($urandom_range(0, 7));
          ram_sel = CFG_W'($urandom_range(0, 7));
        end
      endcase
      if (phase[0]) begin
        write_reg(CFG_RAM_COUNT, ram_sel);
        write_reg(CFG_ROM_LOG2, rom_sel);
      end else begin
        write_reg(CFG_ROM_LOG2, rom_sel);
        write_reg(CFG_RAM_COUNT, ram_sel);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (n == PhaseItems / 2) drain();
        send_random_access();
      end
    end

    no_gaps = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
